// ===== sv/fmp_pkg.sv =====
// shared types, constants and control store of the fibonacci matrix power core
package fmp_pkg;

   localparam int DEFAULT_EXPONENT_BITS = 63;
   localparam int DEFAULT_ENTRY_BITS    = 64;

   localparam int STEP_BITS = 3;

   typedef logic [STEP_BITS-1:0] step_type;

   localparam step_type STEP_IDLE   = 3'd0;
   localparam step_type STEP_MUL    = 3'd1;
   localparam step_type STEP_SQUARE = 3'd2;
   localparam step_type STEP_STEP   = 3'd3;
   localparam step_type STEP_SHIFT  = 3'd4;
   localparam step_type STEP_EMIT   = 3'd5;

   typedef enum logic [2:0] {
      DP_IDLE,
      DP_MUL,
      DP_SQUARE,
      DP_STEP,
      DP_SHIFT,
      DP_EMIT
   } dp_op_type;

   typedef enum logic [2:0] {
      JMP_NEXT,
      JMP_ALWAYS,
      JMP_NO_START,
      JMP_BIT_CLEAR,
      JMP_MORE_BITS
   } jmp_cond_type;

   typedef struct packed {
      dp_op_type    op;
      jmp_cond_type cond;
      step_type     target;
   } ctrl_word_type;

   typedef struct packed {
      logic bit_set;
      logic more_bits;
   } dp_status_type;

   // control store: square, optional step multiply, shift, repeat per exponent bit
   function automatic ctrl_word_type ucode_rom(step_type addr);
      ctrl_word_type word;
      case (addr)
         STEP_IDLE:   word = '{op: DP_IDLE,   cond: JMP_NO_START,  target: STEP_IDLE};
         STEP_MUL:    word = '{op: DP_MUL,    cond: JMP_NEXT,      target: STEP_IDLE};
         STEP_SQUARE: word = '{op: DP_SQUARE, cond: JMP_BIT_CLEAR, target: STEP_SHIFT};
         STEP_STEP:   word = '{op: DP_STEP,   cond: JMP_NEXT,      target: STEP_IDLE};
         STEP_SHIFT:  word = '{op: DP_SHIFT,  cond: JMP_MORE_BITS, target: STEP_MUL};
         STEP_EMIT:   word = '{op: DP_EMIT,   cond: JMP_ALWAYS,    target: STEP_IDLE};
         default:     word = '{op: DP_IDLE,   cond: JMP_ALWAYS,    target: STEP_IDLE};
      endcase
      return word;
   endfunction

endpackage

// ===== sv/fmp_mulmod.sv =====
// modular product of two entries from three registered half-width partial products
module fmp_mulmod
   import fmp_pkg::*;
#(
   parameter int ENTRY_BITS = DEFAULT_ENTRY_BITS
) (
   input  logic                  clock,
   input  logic                  enable,
   input  logic [ENTRY_BITS-1:0] op_a,
   input  logic [ENTRY_BITS-1:0] op_b,
   output logic [ENTRY_BITS-1:0] product
);

   localparam int HALF = (ENTRY_BITS + 1) / 2;
   localparam int HIGH = ENTRY_BITS - HALF;

   logic [HALF-1:0]      lo_a;
   logic [HALF-1:0]      lo_b;
   logic [HIGH-1:0]      hi_a;
   logic [HIGH-1:0]      hi_b;
   logic [2*HALF-1:0]    full_ll;
   logic [HALF+HIGH-1:0] full_x1;
   logic [HALF+HIGH-1:0] full_x2;
   logic [HIGH-1:0]      cross_sum;

   logic [ENTRY_BITS-1:0] ll_ff;
   logic [ENTRY_BITS-1:0] ll_in;
   logic [HIGH-1:0]       x1_ff;
   logic [HIGH-1:0]       x1_in;
   logic [HIGH-1:0]       x2_ff;
   logic [HIGH-1:0]       x2_in;

   assign lo_a = op_a[HALF-1:0];
   assign lo_b = op_b[HALF-1:0];
   assign hi_a = op_a[ENTRY_BITS-1:HALF];
   assign hi_b = op_b[ENTRY_BITS-1:HALF];

   assign full_ll = lo_a * lo_b;
   assign full_x1 = lo_a * hi_b;
   assign full_x2 = hi_a * lo_b;

   // high by high lands above the word and drops out
   assign ll_in = full_ll[ENTRY_BITS-1:0];
   assign x1_in = full_x1[HIGH-1:0];
   assign x2_in = full_x2[HIGH-1:0];

   always_ff @(posedge clock) begin
      if (enable) begin
         ll_ff <= ll_in;
         x1_ff <= x1_in;
         x2_ff <= x2_in;
      end
   end

   assign cross_sum = x1_ff + x2_ff;
   assign product   = ll_ff + {cross_sum, {HALF{1'b0}}};

endmodule

// ===== sv/fmp_datapath.sv =====
// fibonacci pair registers, exponent shifter, bit counter and three modular multipliers
module fmp_datapath
   import fmp_pkg::*;
#(
   parameter int EXPONENT_BITS = DEFAULT_EXPONENT_BITS,
   parameter int ENTRY_BITS    = DEFAULT_ENTRY_BITS
) (
   input  logic                     clock,
   input  logic                     start,
   input  ctrl_word_type            ctrl,
   input  logic [EXPONENT_BITS-1:0] req_exponent,
   output dp_status_type            status,
   output logic [ENTRY_BITS-1:0]    fib_next,
   output logic [ENTRY_BITS-1:0]    fib_curr,
   output logic [ENTRY_BITS-1:0]    fib_prev
);

   localparam int CNT_BITS = (EXPONENT_BITS > 1) ? $clog2(EXPONENT_BITS) : 1;

   // matrix kept as [[b+d, b], [b, d]]
   logic [ENTRY_BITS-1:0]    b_ff;
   logic [ENTRY_BITS-1:0]    b_in;
   logic [ENTRY_BITS-1:0]    d_ff;
   logic [ENTRY_BITS-1:0]    d_in;
   logic [EXPONENT_BITS-1:0] exp_ff;
   logic [EXPONENT_BITS-1:0] exp_in;
   logic [CNT_BITS-1:0]      cnt_ff;
   logic [CNT_BITS-1:0]      cnt_in;

   logic [ENTRY_BITS-1:0] trace;
   logic [ENTRY_BITS-1:0] prod_bt;
   logic [ENTRY_BITS-1:0] prod_bb;
   logic [ENTRY_BITS-1:0] prod_dd;
   logic                  mul_en;

   // trace of the matrix is b + 2d
   assign trace  = b_ff + {d_ff[ENTRY_BITS-2:0], 1'b0};
   assign mul_en = (ctrl.op == DP_MUL);

   fmp_mulmod #(.ENTRY_BITS(ENTRY_BITS)) u_mul_bt (
      .clock   (clock),
      .enable  (mul_en),
      .op_a    (b_ff),
      .op_b    (trace),
      .product (prod_bt)
   );

   fmp_mulmod #(.ENTRY_BITS(ENTRY_BITS)) u_mul_bb (
      .clock   (clock),
      .enable  (mul_en),
      .op_a    (b_ff),
      .op_b    (b_ff),
      .product (prod_bb)
   );

   fmp_mulmod #(.ENTRY_BITS(ENTRY_BITS)) u_mul_dd (
      .clock   (clock),
      .enable  (mul_en),
      .op_a    (d_ff),
      .op_b    (d_ff),
      .product (prod_dd)
   );

   always_comb begin
      b_in   = b_ff;
      d_in   = d_ff;
      exp_in = exp_ff;
      cnt_in = cnt_ff;
      case (ctrl.op)
         DP_IDLE: begin
            if (start) begin
               b_in   = '0;
               d_in   = ENTRY_BITS'(1);
               exp_in = req_exponent;
               cnt_in = CNT_BITS'(EXPONENT_BITS - 1);
            end
         end
         DP_SQUARE: begin
            b_in = prod_bt;
            d_in = prod_bb + prod_dd;
         end
         DP_STEP: begin
            b_in = b_ff + d_ff;
            d_in = b_ff;
         end
         DP_SHIFT: begin
            exp_in = exp_ff << 1;
            cnt_in = cnt_ff - CNT_BITS'(1);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      b_ff   <= b_in;
      d_ff   <= d_in;
      exp_ff <= exp_in;
      cnt_ff <= cnt_in;
   end

   assign status.bit_set   = exp_ff[EXPONENT_BITS-1];
   assign status.more_bits = (cnt_ff != '0);

   assign fib_next = b_ff + d_ff;
   assign fib_curr = b_ff;
   assign fib_prev = d_ff;

endmodule

// ===== sv/fmp_sequencer.sv =====
// step counter and control store lookup with conditional jumps
module fmp_sequencer
   import fmp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  dp_status_type status,
   output ctrl_word_type ctrl
);

   step_type step_ff;
   step_type step_in;
   logic     jump;

   assign ctrl = ucode_rom(step_ff);

   always_comb begin
      case (ctrl.cond)
         JMP_NEXT:      jump = 1'b0;
         JMP_ALWAYS:    jump = 1'b1;
         JMP_NO_START:  jump = !start;
         JMP_BIT_CLEAR: jump = !status.bit_set;
         JMP_MORE_BITS: jump = status.more_bits;
         default:       jump = 1'b1;
      endcase
   end

   assign step_in = jump ? ctrl.target : step_ff + step_type'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   a_step_in_program: assert property (@(posedge clock) disable iff (reset)
      step_ff <= STEP_EMIT)
      else $error("step counter outside program");

   a_emit_returns_idle: assert property (@(posedge clock) disable iff (reset)
      step_ff == STEP_EMIT |=> step_ff == STEP_IDLE)
      else $error("emit step not followed by idle");

   a_step_only_after_square: assert property (@(posedge clock) disable iff (reset)
      step_ff == STEP_STEP |-> $past(step_ff) == STEP_SQUARE)
      else $error("step multiply entered out of order");

endmodule

// ===== sv/fibonacci_matrix_power_core.sv =====
// top level of the fibonacci matrix power core
// a request is taken while idle; the result entries are valid while the strobe is high and are
// taken at the edge that ends it
// the core takes no new request until it has returned to idle after the strobe
// each exponent bit costs a partial product step, a squaring sum, a shift and, for a one bit,
// a step add, on three shared modular multipliers split into 32 by 32 partial products
// the result strobe lasts one cycle and cannot be stalled; reset returns the sequencer to idle
module fibonacci_matrix_power_core
   import fmp_pkg::*;
#(
   parameter int EXPONENT_BITS = DEFAULT_EXPONENT_BITS,
   parameter int ENTRY_BITS    = DEFAULT_ENTRY_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [EXPONENT_BITS-1:0] req_exponent,
   output logic                     rsp_valid,
   output logic [ENTRY_BITS-1:0]    rsp_entry_top_left,
   output logic [ENTRY_BITS-1:0]    rsp_entry_top_right,
   output logic [ENTRY_BITS-1:0]    rsp_entry_bottom_left,
   output logic [ENTRY_BITS-1:0]    rsp_entry_bottom_right
);

   ctrl_word_type         ctrl;
   dp_status_type         status;
   logic [ENTRY_BITS-1:0] fib_next;
   logic [ENTRY_BITS-1:0] fib_curr;
   logic [ENTRY_BITS-1:0] fib_prev;

   fmp_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .ctrl   (ctrl)
   );

   fmp_datapath #(
      .EXPONENT_BITS (EXPONENT_BITS),
      .ENTRY_BITS    (ENTRY_BITS)
   ) u_datapath (
      .clock        (clock),
      .start        (start),
      .ctrl         (ctrl),
      .req_exponent (req_exponent),
      .status       (status),
      .fib_next     (fib_next),
      .fib_curr     (fib_curr),
      .fib_prev     (fib_prev)
   );

   assign busy      = (ctrl.op != DP_IDLE);
   assign rsp_valid = (ctrl.op == DP_EMIT);

   assign rsp_entry_top_left     = fib_next;
   assign rsp_entry_top_right    = fib_curr;
   assign rsp_entry_bottom_left  = fib_curr;
   assign rsp_entry_bottom_right = fib_prev;

   a_accept_sets_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("request accepted but core not busy");

   a_strobe_single_cycle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid && !busy)
      else $error("result strobe not a single cycle before idle");

   a_strobe_only_when_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe while idle");

endmodule

// ===== dv/tb_top.sv =====
// self-checking testbench of the fibonacci matrix power core
module tb_top;
   import fmp_pkg::*;

   localparam int EXP_W   = DEFAULT_EXPONENT_BITS;
   localparam int ENTRY_W = DEFAULT_ENTRY_BITS;
   localparam int RANDOM_REQUESTS = 1450;
   localparam int SETTLE_CYCLES   = 300;
   localparam int TIMEOUT_CYCLES  = 4_000_000;

   typedef logic [ENTRY_W-1:0] entry_type;

   typedef struct {
      entry_type top_left;
      entry_type top_right;
      entry_type bottom_left;
      entry_type bottom_right;
   } fib_matrix_type;

   typedef struct {
      logic [EXP_W-1:0] exponent;
      bit               drain_first;
   } power_request_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [EXP_W-1:0]   req_exponent = '0;
   logic               rsp_valid;
   entry_type          rsp_entry_top_left;
   entry_type          rsp_entry_top_right;
   entry_type          rsp_entry_bottom_left;
   entry_type          rsp_entry_bottom_right;

   power_request_type  pending_requests[$];
   fib_matrix_type     expected_powers[$];
   int unsigned        accepted_count = 0;
   int unsigned        checked_count = 0;
   int unsigned        error_count = 0;
   int unsigned        burst_left = 1;
   int unsigned        gap_left = 0;

   fibonacci_matrix_power_core dut (
      .clock                  (clock),
      .reset                  (reset),
      .start                  (start),
      .busy                   (busy),
      .req_exponent           (req_exponent),
      .rsp_valid              (rsp_valid),
      .rsp_entry_top_left     (rsp_entry_top_left),
      .rsp_entry_top_right    (rsp_entry_top_right),
      .rsp_entry_bottom_left  (rsp_entry_bottom_left),
      .rsp_entry_bottom_right (rsp_entry_bottom_right)
   );

   always #5 clock = ~clock;

   function automatic fib_matrix_type matrix_product(fib_matrix_type x, fib_matrix_type y);
      fib_matrix_type r;
      r.top_left     = x.top_left * y.top_left + x.top_right * y.bottom_left;
      r.top_right    = x.top_left * y.top_right + x.top_right * y.bottom_right;
      r.bottom_left  = x.bottom_left * y.top_left + x.bottom_right * y.bottom_left;
      r.bottom_right = x.bottom_left * y.top_right + x.bottom_right * y.bottom_right;
      return r;
   endfunction

   // square and multiply from the top exponent bit down
   function automatic fib_matrix_type fib_matrix_power(logic [EXP_W-1:0] n);
      fib_matrix_type acc;
      fib_matrix_type base;
      acc.top_left      = 1;
      acc.top_right     = 0;
      acc.bottom_left   = 0;
      acc.bottom_right  = 1;
      base.top_left     = 1;
      base.top_right    = 1;
      base.bottom_left  = 1;
      base.bottom_right = 0;
      for (int i = EXP_W - 1; i >= 0; i--) begin
         acc = matrix_product(acc, acc);
         if (n[i])
            acc = matrix_product(acc, base);
      end
      return acc;
   endfunction

   function automatic logic [EXP_W-1:0] random_exponent();
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      case ($urandom_range(0, 3))
         0: raw = 64'($urandom_range(0, 200));
         1: raw = raw >> $urandom_range(0, 63);
         2: raw = (64'd1 << $urandom_range(0, EXP_W - 1)) - 64'($urandom_range(0, 1));
         default: ;
      endcase
      return raw[EXP_W-1:0];
   endfunction

   task automatic queue_request(logic [EXP_W-1:0] n, bit drain);
      power_request_type r;
      r.exponent    = n;
      r.drain_first = drain;
      pending_requests.push_back(r);
   endtask

   task automatic check_entry(string name, entry_type want, entry_type got);
      if (want !== got) begin
         $error("%s mismatch: expected %h, actual %h", name, want, got);
         error_count++;
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_powers.push_back(fib_matrix_power(req_exponent));
            accepted_count <= accepted_count + 1;
            void'(pending_requests.pop_front());
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 8);
               gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 300);
            end
         end
         if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_requests.size() == 0) begin
            start <= 1'b0;
         end else if (pending_requests[0].drain_first &&
                      ((start && !busy) || checked_count != accepted_count)) begin
            start <= 1'b0;
         end else begin
            start <= 1'b1;
            req_exponent <= pending_requests[0].exponent;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      fib_matrix_type want;
      if (!reset && rsp_valid) begin
         if (expected_powers.size() == 0) begin
            $error("unexpected result strobe: no request outstanding");
            error_count++;
         end else begin
            want = expected_powers.pop_front();
            check_entry("entry_top_left", want.top_left, rsp_entry_top_left);
            check_entry("entry_top_right", want.top_right, rsp_entry_top_right);
            check_entry("entry_bottom_left", want.bottom_left, rsp_entry_bottom_left);
            check_entry("entry_bottom_right", want.bottom_right, rsp_entry_bottom_right);
            checked_count <= checked_count + 1;
         end
      end
   end

   initial begin
      queue_request(63'd0, 1'b0);
      queue_request(63'd1, 1'b0);
      queue_request(63'd2, 1'b0);
      queue_request(63'd3, 1'b0);
      queue_request(63'd10, 1'b0);
      queue_request(63'd92, 1'b0);
      queue_request(63'd93, 1'b0);
      queue_request(63'd94, 1'b0);
      queue_request(63'd186, 1'b1);
      queue_request(63'h7FFF_FFFF_FFFF_FFFF, 1'b0);
      queue_request(63'h4000_0000_0000_0000, 1'b0);
      queue_request(63'h4000_0000_0000_0001, 1'b0);
      queue_request(63'h7FFF_FFFF_FFFF_FFFE, 1'b0);
      queue_request(63'h5555_5555_5555_5555, 1'b0);
      queue_request(63'h2AAA_AAAA_AAAA_AAAA, 1'b0);
      queue_request(63'h0000_0000_8000_0000, 1'b0);
      queue_request(63'h0000_0000_FFFF_FFFF, 1'b0);
      queue_request(63'h0000_0001_0000_0000, 1'b0);
      queue_request(63'h7FFF_FFFF_0000_0000, 1'b0);
      queue_request(63'd0, 1'b0);
      queue_request(63'd47, 1'b1);
      for (int i = 0; i < RANDOM_REQUESTS; i++)
         queue_request(random_exponent(), $urandom_range(0, 149) == 0);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      do
         @(negedge clock);
      while (pending_requests.size() != 0 || accepted_count != checked_count);
      repeat (SETTLE_CYCLES) @(negedge clock);

      if (error_count == 0 && expected_powers.size() == 0)
         $display("fibonacci_matrix_power_core verification clean");
      else
         $display("fibonacci_matrix_power_core verification failed");
      $finish;
   end

   initial begin
      #(TIMEOUT_CYCLES * 10);
      $display("fibonacci_matrix_power_core verification failed");
      $finish;
   end

endmodule
